/* hdl/directed_edge_table_engine_defines.svh */
// Assertion helpers for the edge table engine.
`ifndef DIRECTED_EDGE_TABLE_ENGINE_DEFINES_SVH
`define DIRECTED_EDGE_TABLE_ENGINE_DEFINES_SVH

// Clocked check, muted while reset is held.
`define DETBL_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on the next edge.
`define DETBL_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/detbl_pkg.sv */
package detbl_pkg;

    localparam int DefMaxEdges   = 32;
    localparam int DefKeySpace   = 256;
    localparam int DefPayloadBits = 32;

    typedef enum logic [3:0] {
        MODE_ADD_AUTO  = 4'd0,
        MODE_ADD_KEYED = 4'd1,
        MODE_DEL_NODE  = 4'd2,
        MODE_ADD_EDGE  = 4'd3,
        MODE_DEL_EDGE  = 4'd4,
        MODE_OUT_NB    = 4'd5,
        MODE_IN_NB     = 4'd6,
        MODE_ALL_NB    = 4'd7,
        MODE_READ_EDGE = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_AUTO,
        S_PUT,
        S_KC_RD,
        S_KC_WR,
        S_EC_RD,
        S_EC_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NB_RD,
        S_NB_CHK,
        S_NB_PAY,
        S_RE,
        S_FIN
    } state_t;

endpackage

/* hdl/directed_edge_table_engine.sv */
// Directed edge table engine. One command beat is taken at a time; s_tready is
// high only while the engine is idle. A failed lookup or an unused mode goes
// straight to its result. An auto-key add skips the key read while the key list
// is empty. An edge add scans every stored edge; a duplicate stops the scan
// early. An edge remove walks every stored edge. A node remove walks the listed
// keys, then the stored edges. A listing scans the stored edges in each pass;
// the all-neighbours mode makes two passes. m_tready stalls can hold the engine
// in its result states. The key, payload and edge memories have registered
// reads. Every command returns at least one result beat, and the final beat of
// a command carries m_tlast.
`include "directed_edge_table_engine_defines.svh"

module directed_edge_table_engine
    import detbl_pkg::*;
#(
    parameter int MAX_EDGES    = DefMaxEdges,
    parameter int KEY_SPACE    = DefKeySpace,
    parameter int PAYLOAD_BITS = DefPayloadBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    // mode[3:0], key_a[11:4], key_b[19:12], node_ref[51:20], edge_index[56:52]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0], found[2], result_key[10:3], result_ref[42:11],
    // edge_source[50:43], edge_target[58:51]
    output logic [63:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast
);

    localparam int KeyLimit = (KEY_SPACE < 256) ? KEY_SPACE : 256;
    localparam int KW  = $clog2(KeyLimit);
    localparam int KCW = $clog2(KeyLimit + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int PW  = (KCW > ECW) ? KCW : ECW;

    // memories
    logic [7:0]              key_mem  [KeyLimit];
    logic [PAYLOAD_BITS-1:0] pay_mem  [KeyLimit];
    logic [15:0]             edge_mem [MAX_EDGES];

    logic [7:0]              key_rd_reg;
    logic [PAYLOAD_BITS-1:0] pay_rd_reg;
    logic [15:0]             edge_rd_reg;

    logic          k_we;
    logic [KW-1:0] k_waddr, k_raddr;
    logic [7:0]    k_wdata;
    logic          p_we;
    logic [KW-1:0] p_waddr, p_raddr;
    logic          e_we;
    logic [EW-1:0] e_waddr, e_raddr;
    logic [15:0]   e_wdata;

    // control and data registers
    state_t state_reg, state_next;
    logic [3:0]              mode_reg;
    logic [7:0]              ka_reg, kb_reg;
    logic [PAYLOAD_BITS-1:0] ref_reg;
    logic [4:0]              idx_reg;
    logic [KeyLimit-1:0]     present_reg;
    logic [KCW-1:0]          key_cnt_reg, key_cnt_next;
    logic [ECW-1:0]          edge_cnt_reg, edge_cnt_next;
    logic [PW-1:0]           rd_reg, rd_next, wr_reg, wr_next;
    logic                    hit_reg, hit_next;
    logic                    dir_reg, dir_next;
    logic                    pend_reg, pend_next;
    logic [7:0]              nkey_reg, nkey_next;
    logic [7:0]              nb_reg, nb_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic        res_found_reg, res_found_next;
    logic [7:0]  res_key_reg, res_key_next;
    logic [31:0] res_ref_reg, res_ref_next;
    logic [7:0]  res_src_reg, res_src_next;
    logic [7:0]  res_dst_reg, res_dst_next;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_last_reg;
    logic        out_load, out_load_last;

    logic        pres_set, pres_clr;
    logic [KW-1:0] pres_idx;

    logic s_fire, can_load;
    logic pa, pb;
    logic [8:0] auto_key;
    logic [7:0] e_src, e_dst;
    logic [63:0] ref_wide;
    logic [63:0] pay_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign can_load = !out_valid_reg || m_tready;

    assign pa = ({1'b0, ka_reg} < 9'(KeyLimit)) && present_reg[ka_reg[KW-1:0]];
    assign pb = ({1'b0, kb_reg} < 9'(KeyLimit)) && present_reg[kb_reg[KW-1:0]];
    assign auto_key = {1'b0, key_rd_reg} + 9'd1;
    assign e_src = edge_rd_reg[15:8];
    assign e_dst = edge_rd_reg[7:0];
    assign ref_wide = 64'(s_tdata[51:20]);
    assign pay_wide = 64'(pay_rd_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (mode_reg)
                    MODE_ADD_AUTO:
                        state_next = (key_cnt_reg == '0) ? S_PUT : S_AUTO;
                    MODE_ADD_KEYED:
                        state_next = ({1'b0, ka_reg} < 9'(KeyLimit)) ? S_PUT : S_FIN;
                    MODE_DEL_NODE:
                        state_next = pa ? S_KC_RD : S_FIN;
                    MODE_ADD_EDGE:
                        state_next = (pa && pb) ? S_SCAN_RD : S_FIN;
                    MODE_DEL_EDGE:
                        state_next = (pa && pb) ? S_EC_RD : S_FIN;
                    MODE_OUT_NB, MODE_IN_NB, MODE_ALL_NB:
                        state_next = pa ? S_NB_RD : S_FIN;
                    MODE_READ_EDGE:
                        state_next = ({{ECW{1'b0}}, idx_reg} < {5'b0, edge_cnt_reg})
                                     ? S_RE : S_FIN;
                    default: state_next = S_FIN;
                endcase
            end
            S_AUTO:     state_next = (auto_key >= 9'(KeyLimit)) ? S_FIN : S_PUT;
            S_PUT:      state_next = S_FIN;
            S_KC_RD:    state_next = (rd_reg == PW'(key_cnt_reg)) ? S_EC_RD : S_KC_WR;
            S_KC_WR:    state_next = S_KC_RD;
            S_EC_RD:    state_next = (rd_reg == PW'(edge_cnt_reg)) ? S_FIN : S_EC_WR;
            S_EC_WR:    state_next = S_EC_RD;
            S_SCAN_RD:  state_next = (rd_reg == PW'(edge_cnt_reg)) ? S_FIN : S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (e_src == ka_reg && e_dst == kb_reg) state_next = S_FIN;
                else state_next = S_SCAN_RD;
            end
            S_NB_RD: begin
                if (rd_reg != PW'(edge_cnt_reg)) state_next = S_NB_CHK;
                else if (!(dir_reg == 1'b0 && mode_reg == MODE_ALL_NB)) state_next = S_FIN;
            end
            S_NB_CHK: begin
                if ((dir_reg ? e_src : e_dst) == ka_reg) state_next = S_NB_PAY;
                else state_next = S_NB_RD;
            end
            S_NB_PAY: begin
                if (!pend_reg || can_load) state_next = S_NB_RD;
            end
            S_RE:  state_next = S_FIN;
            S_FIN: begin
                if (can_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        key_cnt_next    = key_cnt_reg;
        edge_cnt_next   = edge_cnt_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        hit_next        = hit_reg;
        dir_next        = dir_reg;
        pend_next       = pend_reg;
        nkey_next       = nkey_reg;
        nb_next         = nb_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_key_next    = res_key_reg;
        res_ref_next    = res_ref_reg;
        res_src_next    = res_src_reg;
        res_dst_next    = res_dst_reg;
        k_we = 1'b0; k_waddr = key_cnt_reg[KW-1:0]; k_wdata = nkey_reg;
        k_raddr = rd_reg[KW-1:0];
        p_we = 1'b0; p_waddr = nkey_reg[KW-1:0]; p_raddr = nb_reg[KW-1:0];
        e_we = 1'b0; e_waddr = wr_reg[EW-1:0]; e_wdata = edge_rd_reg;
        e_raddr = rd_reg[EW-1:0];
        pres_set = 1'b0; pres_clr = 1'b0; pres_idx = nkey_reg[KW-1:0];
        out_load = 1'b0; out_load_last = 1'b0;

        case (state_reg)
            S_DISPATCH: begin
                res_status_next = ST_ABSENT;
                res_found_next  = 1'b0;
                res_key_next    = '0;
                res_ref_next    = '0;
                res_src_next    = '0;
                res_dst_next    = '0;
                rd_next  = '0;
                wr_next  = '0;
                hit_next = 1'b0;
                pend_next = 1'b0;
                dir_next = (mode_reg == MODE_OUT_NB);
                nkey_next = (mode_reg == MODE_ADD_AUTO) ? 8'd0 : ka_reg;
                k_raddr = KW'(key_cnt_reg - KCW'(1));
                e_raddr = idx_reg[EW-1:0];
            end
            S_AUTO: begin
                nkey_next = auto_key[7:0];
                res_status_next = ST_FULL;
            end
            S_PUT: begin
                if (!present_reg[nkey_reg[KW-1:0]]) begin
                    k_we = 1'b1;
                    key_cnt_next = key_cnt_reg + KCW'(1);
                end
                pres_set = 1'b1;
                p_we = 1'b1;
                res_status_next = ST_OK;
                res_found_next  = 1'b1;
                res_key_next    = nkey_reg;
                res_ref_next    = 32'(64'(ref_reg));
            end
            S_KC_RD: begin
                if (rd_reg == PW'(key_cnt_reg)) begin
                    key_cnt_next = wr_reg[KCW-1:0];
                    rd_next = '0;
                    wr_next = '0;
                end else begin
                    rd_next = rd_reg + PW'(1);
                end
            end
            S_KC_WR: begin
                if (key_rd_reg != ka_reg) begin
                    k_we = 1'b1;
                    k_waddr = wr_reg[KW-1:0];
                    k_wdata = key_rd_reg;
                    wr_next = wr_reg + PW'(1);
                end
            end
            S_EC_RD: begin
                if (rd_reg == PW'(edge_cnt_reg)) begin
                    edge_cnt_next = wr_reg[ECW-1:0];
                    if (mode_reg == MODE_DEL_NODE) begin
                        pres_clr = 1'b1;
                        pres_idx = ka_reg[KW-1:0];
                        res_status_next = ST_OK;
                    end else begin
                        res_status_next = hit_reg ? ST_OK : ST_ABSENT;
                    end
                end else begin
                    rd_next = rd_reg + PW'(1);
                end
            end
            S_EC_WR: begin
                if (mode_reg == MODE_DEL_NODE ? (e_src == ka_reg || e_dst == ka_reg)
                                              : (e_src == ka_reg && e_dst == kb_reg)) begin
                    hit_next = 1'b1;
                end else begin
                    e_we = 1'b1;
                    wr_next = wr_reg + PW'(1);
                end
            end
            S_SCAN_RD: begin
                if (rd_reg == PW'(edge_cnt_reg)) begin
                    if (edge_cnt_reg >= ECW'(MAX_EDGES)) begin
                        res_status_next = ST_FULL;
                    end else begin
                        e_we = 1'b1;
                        e_waddr = edge_cnt_reg[EW-1:0];
                        e_wdata = {ka_reg, kb_reg};
                        edge_cnt_next = edge_cnt_reg + ECW'(1);
                        res_status_next = ST_OK;
                    end
                end else begin
                    rd_next = rd_reg + PW'(1);
                end
            end
            S_SCAN_CHK: begin
                res_status_next = ST_DUPLICATE;
            end
            S_NB_RD: begin
                if (rd_reg != PW'(edge_cnt_reg)) begin
                    rd_next = rd_reg + PW'(1);
                end else if (dir_reg == 1'b0 && mode_reg == MODE_ALL_NB) begin
                    dir_next = 1'b1;
                    rd_next = '0;
                end else if (!pend_reg) begin
                    res_status_next = ST_OK;
                    res_found_next  = 1'b0;
                    res_key_next    = '0;
                    res_ref_next    = '0;
                end
            end
            S_NB_CHK: begin
                nb_next = dir_reg ? e_dst : e_src;
                p_raddr = nb_next[KW-1:0];
            end
            S_NB_PAY: begin
                // hold one neighbour back so the final one can carry tlast
                if (!pend_reg || can_load) begin
                    out_load = pend_reg;
                    pend_next = 1'b1;
                    res_status_next = ST_OK;
                    res_found_next  = 1'b1;
                    res_key_next    = nb_reg;
                    res_ref_next    = pay_wide[31:0];
                end
            end
            S_RE: begin
                res_status_next = ST_OK;
                res_found_next  = 1'b1;
                res_src_next    = e_src;
                res_dst_next    = e_dst;
            end
            S_FIN: begin
                out_load = can_load;
                out_load_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (k_we) key_mem[k_waddr] <= k_wdata;
        key_rd_reg <= key_mem[k_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) pay_mem[p_waddr] <= ref_reg;
        pay_rd_reg <= pay_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (e_we) edge_mem[e_waddr] <= e_wdata;
        edge_rd_reg <= edge_mem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            key_cnt_reg   <= '0;
            edge_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            key_cnt_reg  <= key_cnt_next;
            edge_cnt_reg <= edge_cnt_next;
            pend_reg     <= pend_next;
            if (pres_set) present_reg[pres_idx] <= 1'b1;
            if (pres_clr) present_reg[pres_idx] <= 1'b0;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= s_tdata[3:0];
            ka_reg   <= s_tdata[11:4];
            kb_reg   <= s_tdata[19:12];
            ref_reg  <= ref_wide[PAYLOAD_BITS-1:0];
            idx_reg  <= s_tdata[56:52];
        end
        rd_reg         <= rd_next;
        wr_reg         <= wr_next;
        hit_reg        <= hit_next;
        dir_reg        <= dir_next;
        nkey_reg       <= nkey_next;
        nb_reg         <= nb_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_key_reg    <= res_key_next;
        res_ref_reg    <= res_ref_next;
        res_src_reg    <= res_src_next;
        res_dst_reg    <= res_dst_next;
        if (out_load) begin
            out_data_reg <= {5'b0, res_dst_reg, res_src_reg, res_ref_reg, res_key_reg,
                             res_found_reg, res_status_reg};
            out_last_reg <= out_load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `DETBL_CHECK(a_edge_cnt_bound, edge_cnt_reg <= ECW'(MAX_EDGES), "edge count overflow")
    `DETBL_CHECK(a_key_cnt_bound, key_cnt_reg <= KCW'(KeyLimit), "key count overflow")
    `DETBL_NEXT(a_accept_dispatch, s_fire, state_reg == S_DISPATCH, "accept without dispatch")
    `DETBL_NEXT(a_fin_last, state_reg == S_FIN && can_load, m_tvalid && m_tlast,
                "final beat lost")

endmodule
